[rtl/lpsbb_pkg.sv]
`timescale 1ns / 1ps

package lpsbb_pkg;

   // Grid extent and storage shape
   localparam int unsigned GRID_MAX = 63;
   localparam int unsigned COORD_W  = 6;
   localparam int unsigned ROW_W    = 1 << COORD_W;
   localparam int unsigned NUM_ROWS = 1 << COORD_W;
   localparam int unsigned ROW_LAST = NUM_ROWS - 1;
   localparam int unsigned COUNT_W  = 13;
   localparam int unsigned FUNC_W   = 2;

   // Highest coordinate that addresses a point, and the empty-set minimum
   localparam logic [COORD_W-1:0] COORD_TOP =
      (GRID_MAX > ROW_LAST) ? COORD_W'(ROW_LAST) : COORD_W'(GRID_MAX);
   localparam logic [COORD_W-1:0] EMPTY_LEAST = COORD_W'(GRID_MAX);
   localparam logic [COORD_W-1:0] LAST_INDEX  = COORD_W'(ROW_LAST);

   // Stream word widths
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 40;

   // Operation codes
   typedef enum logic [FUNC_W-1:0] {
      OP_TOGGLE = 2'd0,
      OP_QUERY  = 2'd1,
      OP_REPORT = 2'd2
   } op_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SCAN_ROWS,
      ST_SCAN_LAST,
      ST_SCAN_BITS,
      ST_REPORT
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load_item;
      logic item_done;
      logic row_read;
      logic bits_start;
      logic bit_step;
      logic report_done;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic row_last;
      logic bit_last;
      logic out_free;
   } status_type;

endpackage

[rtl/lit_point_set_with_bounding_box.sv]
`timescale 1ns / 1ps
// Toggle and query: one memory read, then for a toggle one write, then the result is registered.
// Report: a 64-row sweep of the bitmap
// (one row per cycle on the single read port) and the 64-bit column sweep after it.
// One item is in work at a time; the result register lets the next item enter early.
// Reset (synchronous, active high) empties the set at once through per-row valid bits.

module lit_point_set_with_bounding_box
   import lpsbb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // x_coord[5:0], y_coord[11:6], zero pad
   input  logic [FUNC_W-1:0]     req_tuser,   // func[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // point_lit[0], lit_total[13:1],
                                              // x_least[19:14], x_greatest[25:20],
                                              // y_least[31:26], y_greatest[37:32], zero pad
);

   cmd_type    cmd;
   status_type status;

   lpsbb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   lpsbb_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_func   (req_tuser),
      .req_x      (req_tdata[COORD_W-1:0]),
      .req_y      (req_tdata[2*COORD_W-1:COORD_W]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[rtl/lpsbb_ctrl.sv]
`timescale 1ns / 1ps

module lpsbb_ctrl
   import lpsbb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [FUNC_W-1:0] req_func,
   input  status_type        status,
   output cmd_type           cmd
);

   state_type state_ff;
   state_type state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_func == FUNC_W'(OP_REPORT)) begin
                  state_in = ST_SCAN_ROWS;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN_ROWS: begin
            if (status.row_last) begin
               state_in = ST_SCAN_LAST;
            end
         end
         ST_SCAN_LAST: begin
            state_in = ST_SCAN_BITS;
         end
         ST_SCAN_BITS: begin
            if (status.bit_last) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.load_item = req_tvalid;
         end
         ST_UPDATE: begin
            cmd.item_done = status.out_free;
         end
         ST_SCAN_ROWS: begin
            cmd.row_read = 1'b1;
         end
         ST_SCAN_LAST: begin
            cmd.bits_start = 1'b1;
         end
         ST_SCAN_BITS: begin
            cmd.bit_step = 1'b1;
         end
         ST_REPORT: begin
            cmd.report_done = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Checks
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

   a_bits_after_rows: assert property (@(posedge clock) disable iff (reset)
      cmd.bits_start |-> $past(cmd.row_read) && $past(status.row_last))
      else $error("bit sweep started before the last row was read");

endmodule

[rtl/lpsbb_dpath.sv]
`timescale 1ns / 1ps

module lpsbb_dpath
   import lpsbb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [COORD_W-1:0]    req_x,
   input  logic [COORD_W-1:0]    req_y,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Bitmap storage, one row per y, and a cleared-at-reset valid bit per row
   logic [ROW_W-1:0]    rows_mem [NUM_ROWS];
   logic [NUM_ROWS-1:0] row_valid_ff;

   // Item registers
   logic [FUNC_W-1:0]  func_ff;
   logic [COORD_W-1:0] x_ff;
   logic [COORD_W-1:0] y_ff;

   // Read port
   logic [COORD_W-1:0] rd_addr;
   logic               rd_en;
   logic [ROW_W-1:0]   rd_data_ff;
   logic               rd_valid_ff;
   logic [COORD_W-1:0] rd_row_ff;
   logic [ROW_W-1:0]   rd_row_bits;

   // Scan state
   logic [COORD_W-1:0] scan_idx_ff;
   logic               acc_pend_ff;
   logic [ROW_W-1:0]   cols_ff;
   logic               yany_ff;
   logic [COORD_W-1:0] ymin_ff;
   logic [COORD_W-1:0] ymax_ff;
   logic               xany_ff;
   logic [COORD_W-1:0] xmin_ff;
   logic [COORD_W-1:0] xmax_ff;
   logic [COORD_W-1:0] bit_idx_ff;

   // Count and result
   logic [COUNT_W-1:0]    lit_count_ff;
   logic [COUNT_W-1:0]    lit_count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   logic             coord_ok;
   logic             old_bit;
   logic [ROW_W-1:0] new_row;
   logic             do_toggle;
   logic             item_lit;

   // Read address: the new item's row on accept, else the scan row
   assign rd_en   = cmd.load_item | cmd.row_read;
   assign rd_addr = cmd.load_item ? req_y : scan_idx_ff;

   // Invalid rows read as empty
   assign rd_row_bits = rd_valid_ff ? rd_data_ff : '0;

   // Point access decode
   assign coord_ok  = (x_ff <= COORD_TOP) && (y_ff <= COORD_TOP);
   assign old_bit   = rd_row_bits[x_ff];
   assign new_row   = rd_row_bits ^ (ROW_W'(1) << x_ff);
   assign do_toggle = cmd.item_done && (func_ff == FUNC_W'(OP_TOGGLE)) && coord_ok;

   // Status
   assign status.row_last = (scan_idx_ff == LAST_INDEX);
   assign status.bit_last = (bit_idx_ff == LAST_INDEX);
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   // Registered memory read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= rows_mem[rd_addr];
         rd_valid_ff <= row_valid_ff[rd_addr];
         rd_row_ff   <= rd_addr;
      end
   end

   // Memory write on toggle
   always_ff @(posedge clock) begin
      if (do_toggle) begin
         rows_mem[y_ff] <= new_row;
      end
   end

   // Row valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (do_toggle) begin
         row_valid_ff[y_ff] <= 1'b1;
      end
   end

   // Latch the item
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         func_ff <= req_func;
         x_ff    <= req_x;
         y_ff    <= req_y;
      end
   end

   // Row sweep: read one row a cycle, fold the previous one in
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_pend_ff <= 1'b0;
      end else begin
         acc_pend_ff <= cmd.row_read;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         scan_idx_ff <= '0;
         cols_ff     <= '0;
         yany_ff     <= 1'b0;
         ymin_ff     <= EMPTY_LEAST;
         ymax_ff     <= '0;
      end else begin
         if (cmd.row_read) begin
            scan_idx_ff <= scan_idx_ff + COORD_W'(1);
         end
         if (acc_pend_ff && (rd_row_bits != '0)) begin
            cols_ff <= cols_ff | rd_row_bits;
            yany_ff <= 1'b1;
            ymax_ff <= rd_row_ff;
            if (!yany_ff) begin
               ymin_ff <= rd_row_ff;
            end
         end else if (cmd.bit_step) begin
            cols_ff <= cols_ff >> 1;
         end
      end
   end

   // Bit sweep over the column union: one bit a cycle
   always_ff @(posedge clock) begin
      if (cmd.bits_start) begin
         bit_idx_ff <= '0;
         xany_ff    <= 1'b0;
         xmin_ff    <= EMPTY_LEAST;
         xmax_ff    <= '0;
      end else if (cmd.bit_step) begin
         bit_idx_ff <= bit_idx_ff + COORD_W'(1);
         if (cols_ff[0]) begin
            xany_ff <= 1'b1;
            xmax_ff <= bit_idx_ff;
            if (!xany_ff) begin
               xmin_ff <= bit_idx_ff;
            end
         end
      end
   end

   // Lit count
   always_comb begin
      lit_count_in = lit_count_ff;
      if (do_toggle) begin
         if (old_bit) begin
            lit_count_in = lit_count_ff - COUNT_W'(1);
         end else begin
            lit_count_in = lit_count_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lit_count_ff <= '0;
      end else begin
         lit_count_ff <= lit_count_in;
      end
   end

   // Result word
   always_comb begin
      item_lit = 1'b0;
      case (func_ff)
         OP_TOGGLE: item_lit = coord_ok && !old_bit;
         OP_QUERY:  item_lit = coord_ok && old_bit;
         default:   item_lit = 1'b0;
      endcase
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.item_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(RSP_DATA_W - 1){1'b0}}, item_lit};
      end else if (cmd.report_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, ymax_ff, ymin_ff, xmax_ff, xmin_ff, lit_count_ff, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks
   a_finish_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.item_done || cmd.report_done) |-> status.out_free)
      else $error("result loaded over a word not yet taken");

   a_toggle_moves_count: assert property (@(posedge clock) disable iff (reset)
      do_toggle |=> (lit_count_ff != $past(lit_count_ff)))
      else $error("toggle left the lit count unchanged");

   a_box_ordered: assert property (@(posedge clock) disable iff (reset)
      (cmd.report_done && yany_ff) |-> (xany_ff && (xmin_ff <= xmax_ff)
                                        && (ymin_ff <= ymax_ff)))
      else $error("bounding box out of order on a nonempty set");

endmodule

[dv/tb_lit_point_set_with_bounding_box.sv]
`timescale 1ns / 1ps

module tb_lit_point_set_with_bounding_box
   import lpsbb_pkg::*;
();

   // Run limits: the cycle cap allows several slow runs
   localparam int          CYCLE_LIMIT   = 1_000_000;
   localparam int          SETTLE_CYCLES = 200;
   localparam int          ITEM_TARGET   = 1300;
   localparam logic [1:0]  OP_UNUSED     = 2'd3;

   // One command word as the driver sends it
   typedef struct {
      logic [FUNC_W-1:0]  func;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      bit                 wait_drain;
      bit                 steady;
   } point_cmd_type;

   // Result word, highest field first so it maps straight onto rsp_tdata
   typedef struct packed {
      logic [1:0]         pad;
      logic [COORD_W-1:0] y_greatest;
      logic [COORD_W-1:0] y_least;
      logic [COORD_W-1:0] x_greatest;
      logic [COORD_W-1:0] x_least;
      logic [COUNT_W-1:0] lit_total;
      logic               point_lit;
   } grid_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [FUNC_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   point_cmd_type         pending_cmds [$];
   grid_result_type       due_results [$];

   // Predictor state
   logic [ROW_W-1:0]      grid_model [NUM_ROWS];
   logic [COUNT_W-1:0]    lit_tally;

   // Generator shadow of the set, used to build sequences that hit real points
   bit   [ROW_W-1:0]      shadow_rows [NUM_ROWS];
   logic [2*COORD_W-1:0]  lit_pts [$];

   logic                  quiet_window = 1'b0;
   int                    error_count  = 0;
   int                    cycle_count  = 0;
   int                    op_seen [4]  = '{0, 0, 0, 0};
   int                    empty_reports = 0;
   int                    peak_lit     = 0;

   lit_point_set_with_bounding_box u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Flag one mismatch with a single line
   task automatic report_mismatch(string what, int got, int want);
      error_count++;
      $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   function automatic bit in_grid(logic [COORD_W-1:0] v);
      return v <= GRID_MAX;
   endfunction

   // Compute the result of one command and advance the predicted set
   function automatic grid_result_type predict_response(point_cmd_type c);
      grid_result_type  r;
      logic [ROW_W-1:0] cols;
      bit               any_lit;
      r       = '0;
      cols    = '0;
      any_lit = 0;
      case (c.func)
         OP_TOGGLE: begin
            if (in_grid(c.x) && in_grid(c.y)) begin
               grid_model[c.y][c.x] = ~grid_model[c.y][c.x];
               r.point_lit = grid_model[c.y][c.x];
               lit_tally = r.point_lit ? lit_tally + 1'b1 : lit_tally - 1'b1;
            end
         end
         OP_QUERY: begin
            if (in_grid(c.x) && in_grid(c.y)) r.point_lit = grid_model[c.y][c.x];
         end
         OP_REPORT: begin
            r.lit_total = lit_tally;
            r.x_least   = COORD_W'(GRID_MAX);
            r.y_least   = COORD_W'(GRID_MAX);
            for (int row = 0; row < NUM_ROWS; row++) begin
               if (grid_model[row] != '0) begin
                  if (!any_lit) r.y_least = COORD_W'(row);
                  r.y_greatest = COORD_W'(row);
                  cols |= grid_model[row];
                  any_lit = 1;
               end
            end
            if (any_lit) begin
               for (int b = ROW_W - 1; b >= 0; b--) if (cols[b]) r.x_least = COORD_W'(b);
               for (int b = 0; b < ROW_W; b++) if (cols[b]) r.x_greatest = COORD_W'(b);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Queue one command and keep the shadow set in step with toggles
   task automatic add_cmd(logic [FUNC_W-1:0] func, logic [COORD_W-1:0] x,
                          logic [COORD_W-1:0] y);
      point_cmd_type c;
      int            n;
      n = pending_cmds.size();
      c.func       = func;
      c.x          = x;
      c.y          = y;
      c.wait_drain = (n % 211 == 105);
      c.steady     = (n >= 500 && n < 800);
      pending_cmds.push_back(c);
      if (func == OP_TOGGLE) begin
         shadow_rows[y][x] = ~shadow_rows[y][x];
         if (shadow_rows[y][x]) begin
            lit_pts.push_back({y, x});
         end else begin
            for (int i = 0; i < lit_pts.size(); i++) begin
               if (lit_pts[i] == {y, x}) begin
                  lit_pts.delete(i);
                  break;
               end
            end
         end
      end
   endtask

   // Driver: present the next word when the channel is free
   always @(posedge clock) begin
      point_cmd_type c;
      bit            drained;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         drained = !req_tvalid && due_results.size() == 0 && !(rsp_tvalid && rsp_tready);
         if (pending_cmds.size() > 0 && (!pending_cmds[0].wait_drain || drained) &&
             (pending_cmds[0].steady || $urandom_range(0, 99) >= 15)) begin
            c = pending_cmds.pop_front();
            req_tdata    <= REQ_DATA_W'({c.y, c.x});
            req_tuser    <= c.func;
            quiet_window <= c.steady;
            req_tvalid   <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result side back-pressure
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= quiet_window || ($urandom_range(0, 99) >= 15);
   end

   // Monitor: check results against the oldest prediction, then record new commands
   always @(posedge clock) begin
      grid_result_type got;
      grid_result_type want;
      point_cmd_type   c;
      if (reset) begin
         foreach (grid_model[i]) grid_model[i] = '0;
         lit_tally = '0;
         due_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = grid_result_type'(rsp_tdata);
            if (due_results.size() == 0) begin
               report_mismatch("unexpected result word", int'(rsp_tdata[31:0]), 0);
            end else begin
               want = due_results.pop_front();
               if (got.point_lit !== want.point_lit)
                  report_mismatch("point_lit", int'(got.point_lit), int'(want.point_lit));
               if (got.lit_total !== want.lit_total)
                  report_mismatch("lit_total", int'(got.lit_total), int'(want.lit_total));
               if (got.x_least !== want.x_least)
                  report_mismatch("x_least", int'(got.x_least), int'(want.x_least));
               if (got.x_greatest !== want.x_greatest)
                  report_mismatch("x_greatest", int'(got.x_greatest),
                                  int'(want.x_greatest));
               if (got.y_least !== want.y_least)
                  report_mismatch("y_least", int'(got.y_least), int'(want.y_least));
               if (got.y_greatest !== want.y_greatest)
                  report_mismatch("y_greatest", int'(got.y_greatest),
                                  int'(want.y_greatest));
               if (got.pad !== want.pad)
                  report_mismatch("pad bits", int'(got.pad), int'(want.pad));
            end
         end
         if (req_tvalid && req_tready) begin
            c.func = req_tuser;
            c.x    = req_tdata[COORD_W-1:0];
            c.y    = req_tdata[2*COORD_W-1:COORD_W];
            want   = predict_response(c);
            due_results.push_back(want);
            op_seen[c.func]++;
            if (c.func == OP_REPORT && lit_tally == 0) empty_reports++;
            if (int'(lit_tally) > peak_lit) peak_lit = int'(lit_tally);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, due_results.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Stimulus build and end of run
   initial begin
      int         pick;
      int         bx;
      int         by;
      logic [11:0] p;
      foreach (shadow_rows[i]) shadow_rows[i] = '0;

      // Directed: empty set, corners, alternating bit patterns, unused op
      add_cmd(OP_REPORT, 6'd0, 6'd0);
      add_cmd(OP_TOGGLE, 6'd0, 6'd0);
      add_cmd(OP_TOGGLE, 6'd63, 6'd63);
      add_cmd(OP_QUERY, 6'd0, 6'd0);
      add_cmd(OP_QUERY, 6'd63, 6'd63);
      add_cmd(OP_QUERY, 6'd5, 6'd7);
      add_cmd(OP_REPORT, 6'd0, 6'd0);
      add_cmd(OP_TOGGLE, 6'd63, 6'd0);
      add_cmd(OP_TOGGLE, 6'd0, 6'd63);
      add_cmd(OP_REPORT, 6'd63, 6'd63);
      add_cmd(OP_UNUSED, 6'd63, 6'd63);
      add_cmd(OP_REPORT, 6'd0, 6'd0);
      add_cmd(OP_TOGGLE, 6'd0, 6'd0);
      add_cmd(OP_TOGGLE, 6'd63, 6'd63);
      add_cmd(OP_TOGGLE, 6'd63, 6'd0);
      add_cmd(OP_TOGGLE, 6'd0, 6'd63);
      add_cmd(OP_REPORT, 6'd0, 6'd0);
      add_cmd(OP_TOGGLE, 6'd21, 6'd42);
      add_cmd(OP_TOGGLE, 6'd42, 6'd21);
      add_cmd(OP_QUERY, 6'd42, 6'd21);
      add_cmd(OP_REPORT, 6'd0, 6'd0);
      add_cmd(OP_TOGGLE, 6'd21, 6'd42);
      add_cmd(OP_TOGGLE, 6'd42, 6'd21);
      add_cmd(OP_REPORT, 6'd0, 6'd0);
      pending_cmds[pending_cmds.size()-1].wait_drain = 1;

      // Random: clustered bursts, clears, single toggles, queries, reports and unused ops
      while (pending_cmds.size() < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            bx = ($urandom_range(0, 3) == 0) ? 56 * $urandom_range(0, 1) : $urandom_range(0, 56);
            by = ($urandom_range(0, 3) == 0) ? 56 * $urandom_range(0, 1) : $urandom_range(0, 56);
            repeat ($urandom_range(4, 12))
               add_cmd(OP_TOGGLE, 6'(bx + $urandom_range(0, 7)), 6'(by + $urandom_range(0, 7)));
            add_cmd(OP_REPORT, 6'($urandom), 6'($urandom));
         end else if (pick < 12 && lit_pts.size() <= 48) begin
            while (lit_pts.size() > 0) begin
               p = lit_pts[$urandom_range(0, lit_pts.size() - 1)];
               add_cmd(OP_TOGGLE, p[5:0], p[11:6]);
            end
            add_cmd(OP_REPORT, 6'($urandom), 6'($urandom));
         end else if (pick < 45) begin
            add_cmd(OP_TOGGLE, 6'($urandom), 6'($urandom));
         end else if (pick < 55 && lit_pts.size() > 0) begin
            p = lit_pts[$urandom_range(0, lit_pts.size() - 1)];
            add_cmd(OP_TOGGLE, p[5:0], p[11:6]);
         end else if (pick < 72) begin
            if (lit_pts.size() > 0 && $urandom_range(0, 1)) begin
               p = lit_pts[$urandom_range(0, lit_pts.size() - 1)];
               add_cmd(OP_QUERY, p[5:0], p[11:6]);
            end else begin
               add_cmd(OP_QUERY, 6'($urandom), 6'($urandom));
            end
         end else if (pick < 95) begin
            add_cmd(OP_REPORT, 6'($urandom), 6'($urandom));
         end else begin
            add_cmd(OP_UNUSED, 6'($urandom), 6'($urandom));
         end
      end

      // Release reset
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Drain, then let any stray result show up
      @(posedge clock);
      while (pending_cmds.size() > 0 || req_tvalid || due_results.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("sent %0d toggles, %0d queries, %0d reports, %0d unused-op words",
               op_seen[OP_TOGGLE], op_seen[OP_QUERY], op_seen[OP_REPORT], op_seen[OP_UNUSED]);
      $display("empty-set reports: %0d, peak lit count: %0d, mismatches: %0d",
               empty_reports, peak_lit, error_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
